// ===== hw/rtl/md5_pkg.sv =====
// MD5 package: types, constants, round tables and step functions.
// No dependencies; used by every module of the MD5 block.
`default_nettype none
package md5_pkg;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam int          QDepth = 2;

  // Item passed from the loader to the compression engine.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } md5_job_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index for round i (all mod 16).
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] r;
    r = i[3:0];
    case (i[5:4])
      2'd0: g = r;
      2'd1: g = 4'((r << 2) + r + 4'd1);
      2'd2: g = 4'((r << 1) + r + 4'd5);
      default: g = 4'((r << 3) - r);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/md5_if.sv =====
// Valid/ready channel interfaces for the MD5 block.
// No dependencies.
`default_nettype none
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_of_message;
  modport source (output valid, data_byte, has_byte, last_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, last_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/md5_loader.sv =====
// Front end: gathers bytes into 512-bit blocks and builds padding blocks.
// Depends on md5_pkg and md5_if.
`default_nettype none
module md5_loader import md5_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  md5_in_if.sink    in_ch,
  output md5_job_t  job,
  output logic      job_valid,
  input  wire logic job_ready
);
  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_PAD  = 3'b010,
    S_LEN  = 3'b100
  } ld_state_t;

  ld_state_t    state, state_next;
  logic [511:0] buf_q;
  logic [63:0]  bit_count;
  logic [5:0]   fill;
  logic         push;

  assign fill = bit_count[8:3];
  assign job_valid = push;

  // Byte-lane helpers computed per lane.
  logic [511:0] pad_blk, len_blk;
  logic [5:0]   fill_eff;
  logic         wrap;
  assign fill_eff = in_ch.has_byte ? 6'(fill + 6'd1) : fill;
  assign wrap = in_ch.has_byte && (fill == 6'd63);

  always_comb begin
    pad_blk = buf_q;
    if (in_ch.has_byte) pad_blk[fill*8 +: 8] = in_ch.data_byte;
    for (int b = 0; b < 64; b++) begin
      if (wrap) pad_blk[b*8 +: 8] = (b == 0) ? PadByte : 8'h00;
      else if (b == fill_eff) pad_blk[b*8 +: 8] = PadByte;
      else if (b > fill_eff) pad_blk[b*8 +: 8] = 8'h00;
    end
    len_blk = '0;
    len_blk[511:448] = bit_count;
  end

  logic take;
  assign in_ch.ready = (state == S_LOAD) && job_ready;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    state_next = state;
    push = 1'b0;
    job = '{block: buf_q, final_blk: 1'b0};
    unique case (state)
      S_LOAD: begin
        if (take) begin
          if (in_ch.last_of_message) begin
            push = 1'b1;
            if (!wrap && fill_eff < 6'd56) begin
              job.block = pad_blk;
              job.block[511:448] = in_ch.has_byte ? 64'(bit_count + 64'd8) : bit_count;
              job.final_blk = 1'b1;
            end else begin
              job.block = wrap ? buf_q : pad_blk;
              if (wrap) job.block[511:504] = in_ch.data_byte;
              state_next = wrap ? S_PAD : S_LEN;
            end
          end else if (wrap) begin
            push = 1'b1;
            job.block = buf_q;
            job.block[511:504] = in_ch.data_byte;
          end
        end
      end
      S_PAD: begin
        push = job_ready;
        job.block = '0;
        job.block[7:0] = PadByte;
        job.block[511:448] = bit_count;
        job.final_blk = 1'b1;
        if (job_ready) state_next = S_LOAD;
      end
      S_LEN: begin
        push = job_ready;
        job.block = len_blk;
        job.final_blk = 1'b1;
        if (job_ready) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      bit_count <= '0;
    end else begin
      state <= state_next;
      if (take && in_ch.has_byte) bit_count <= bit_count + 64'd8;
      if ((state == S_PAD || state == S_LEN) && job_ready) bit_count <= '0;
      if (take && in_ch.last_of_message && !wrap && fill_eff < 6'd56) bit_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ch.has_byte) buf_q[fill*8 +: 8] <= in_ch.data_byte;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/md5_queue.sv =====
// Two-entry job queue between loader and compression engine.
// Depends on md5_pkg.
`default_nettype none
module md5_queue import md5_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire md5_job_t wr_job,
  input  wire logic     wr_valid,
  output logic          wr_ready,
  output md5_job_t      rd_job,
  output logic          rd_valid,
  input  wire logic     rd_ready
);
  md5_job_t   mem [QDepth];
  logic       wp, rp;
  logic [1:0] count;
  logic       wr_en, rd_en;

  assign wr_ready = count != 2'(QDepth);
  assign rd_valid = count != 2'd0;
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      count <= 2'(count + {1'b0, wr_en} - {1'b0, rd_en});
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_job;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/md5_engine.sv =====
// Back end: 64-round compression, one round a cycle, and digest output.
// Depends on md5_pkg and md5_if.
`default_nettype none
module md5_engine import md5_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire md5_job_t job,
  input  wire logic     job_valid,
  output logic          job_ready,
  md5_out_if.source     out_ch
);
  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_RUN  = 3'b010,
    E_OUT  = 3'b100
  } eng_state_t;

  eng_state_t   state;
  logic [511:0] blk;
  logic         fin;
  logic [5:0]   rnd;
  logic [1:0]   widx;
  logic [31:0]  h0, h1, h2, h3, a, b, c, d;
  logic [31:0]  f, t, m, rot;
  logic [4:0]   s;

  assign job_ready = (state == E_IDLE);

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    m = blk[md5_g(rnd)*32 +: 32];
    t = a + f + m + md5_k(rnd);
    s = md5_rot(rnd);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  assign out_ch.valid = (state == E_OUT);
  assign out_ch.word_index = widx;
  assign out_ch.last_word = (widx == 2'd3);
  always_comb begin
    case (widx)
      2'd0: out_ch.digest_word = h0;
      2'd1: out_ch.digest_word = h1;
      2'd2: out_ch.digest_word = h2;
      default: out_ch.digest_word = h3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      rnd <= '0;
      widx <= '0;
      h0 <= IvA; h1 <= IvB; h2 <= IvC; h3 <= IvD;
    end else begin
      unique case (state)
        E_IDLE: if (job_valid) begin
          state <= E_RUN;
          rnd <= '0;
        end
        E_RUN: begin
          rnd <= 6'(rnd + 6'd1);
          if (rnd == 6'd63) begin
            h0 <= h0 + d;
            h1 <= h1 + b + rot;
            h2 <= h2 + b;
            h3 <= h3 + c;
            state <= fin ? E_OUT : E_IDLE;
            widx <= '0;
          end
        end
        E_OUT: if (out_ch.ready) begin
          widx <= 2'(widx + 2'd1);
          if (widx == 2'd3) begin
            state <= E_IDLE;
            h0 <= IvA; h1 <= IvB; h2 <= IvC; h3 <= IvD;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  // Working registers; loaded at job start, advanced each round.
  always_ff @(posedge clk) begin
    if (state == E_IDLE && job_valid) begin
      blk <= job.block;
      fin <= job.final_blk;
      a <= h0; b <= h1; c <= h2; d <= h3;
    end else if (state == E_RUN) begin
      a <= d; d <= c; c <= b;
      b <= b + rot;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/md5_message_digest.sv =====
// MD5 message digest top level: loader, job queue and compression engine.
// Depends on md5_pkg, md5_if, md5_loader, md5_queue, md5_engine.
//
// Usage:
//  - in_ch carries one transaction per message byte (data_byte, has_byte,
//    last_of_message). A transaction with last_of_message closes the
//    message; it may carry a byte or none (empty message allowed).
//  - out_ch then delivers four transactions: digest words A..D with
//    word_index 0..3, last_word set on the fourth, one per cycle while
//    out_ch is ready.
//  - Bytes are taken one a cycle while the job queue has room and the
//    loader is not sending a padding block. For each full block the engine
//    takes the job while idle, then runs one round per cycle for 64 rounds,
//    so the sustained byte rate is set by the round loop.
//  - Closing a message queues one or two padding blocks; the first digest
//    word is offered once the engine has compressed the last of them.
//  - A two-entry job queue sits between loader and engine, so the loader
//    keeps taking bytes while a block compresses.
//  - Reset (rst, synchronous) clears the bit count, the queue and loads the
//    initial chaining words. If out_ch stalls, the engine holds the
//    current digest word and new blocks wait in the queue.
`default_nettype none
module md5_message_digest import md5_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);
  md5_job_t ld_job, q_job;
  logic     ld_valid, ld_ready, q_valid, q_ready;

  md5_loader u_loader (
    .clk, .rst, .in_ch,
    .job(ld_job), .job_valid(ld_valid), .job_ready(ld_ready)
  );

  md5_queue u_queue (
    .clk, .rst,
    .wr_job(ld_job), .wr_valid(ld_valid), .wr_ready(ld_ready),
    .rd_job(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  md5_engine u_engine (
    .clk, .rst,
    .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
    .out_ch
  );
endmodule
`default_nettype wire

// ===== sim/md5_digest_checker.sv =====
// Checker for the MD5 message digest block: watches both channels, computes
// expected digests and compares every digest word. Depends on md5_if.
`timescale 1ns / 1ps
module md5_digest_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  md5_in_if          in_mon,
  md5_out_if         out_mon,
  output int         fail_count,
  output int         pending_words
);

  typedef struct {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0] chain [4];
  logic [7:0]  buffer [64];
  logic [63:0] bit_count;
  digest_word_t digest_q[$];

  localparam logic [31:0] Sines [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int Shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                 4, 11, 16, 23, 6, 10, 15, 21};

  task automatic init_state();
    chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
    bit_count = '0;
    foreach (buffer[i]) buffer[i] = '0;
  endtask

  task automatic compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g, s;
    for (int i = 0; i < 16; i++)
      m[i] = {buffer[4*i+3], buffer[4*i+2], buffer[4*i+1], buffer[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = 5 * i + 1; end
        2: begin f = b ^ c ^ d; g = 3 * i + 5; end
        default: begin f = c ^ (b | ~d); g = 7 * i; end
      endcase
      s = Shifts[(i / 16) * 4 + (i % 4)];
      t = a + f + m[g % 16] + Sines[i];
      t = (t << s) | (t >> (32 - s));
      a = d; d = c; c = b; b = b + t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  // Absorb one transaction; on a close, pad and queue the four digest words.
  task automatic absorb(input logic [7:0] data, input logic has, input logic close);
    int fill;
    logic [63:0] len;
    digest_word_t dw;
    fill = int'(bit_count[8:3]);
    if (has) begin
      buffer[fill] = data;
      bit_count += 64'd8;
      fill = (fill + 1) % 64;
      if (fill == 0) compress();
    end
    if (close) begin
      len = bit_count;
      buffer[fill] = 8'h80;
      for (int i = fill + 1; i < 64; i++) buffer[i] = '0;
      if (fill >= 56) begin
        compress();
        for (int i = 0; i < 56; i++) buffer[i] = '0;
      end
      for (int i = 0; i < 8; i++) buffer[56+i] = len[8*i +: 8];
      compress();
      for (int i = 0; i < 4; i++) begin
        dw.word = chain[i]; dw.idx = 2'(i); dw.last = (i == 3);
        digest_q.push_back(dw);
      end
      init_state();
    end
  endtask

  initial begin
    fail_count = 0;
    pending_words = 0;
    init_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      init_state();
    end else begin
      if (in_mon.valid && in_mon.ready)
        absorb(in_mon.data_byte, in_mon.has_byte, in_mon.last_of_message);
      if (out_mon.valid && out_mon.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time,
                   out_mon.digest_word, out_mon.word_index);
          fail_count++;
        end else begin
          if (out_mon.digest_word !== digest_q[0].word ||
              out_mon.word_index !== digest_q[0].idx ||
              out_mon.last_word !== digest_q[0].last) begin
            $display("%0t: digest mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                     $time, digest_q[0].word, digest_q[0].idx, digest_q[0].last,
                     out_mon.digest_word, out_mon.word_index, out_mon.last_word);
            fail_count++;
          end
          void'(digest_q.pop_front());
        end
      end
    end
    pending_words = digest_q.size();
  end

endmodule

// ===== sim/md5_message_digest_tb.sv =====
// Testbench top for md5_message_digest: drives messages byte by byte with
// bursty timing and stalls; depends on md5_if, md5_message_digest, md5_digest_checker.
`timescale 1ns / 1ps
module md5_message_digest_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_words;
  int   stall_hold = 0;   // cycles the receiver must still hold off
  int   items_sent = 0;
  bit   stim_done = 1'b0;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  always #6 clk = ~clk;

  md5_message_digest DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  md5_digest_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_words(pending_words));

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.last_of_message = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stall pattern, quiet stretches, and long hold-offs
  // requested by the stimulus to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 3))
        0: out_ch.ready <= ($urandom_range(0, 9) != 0);
        1: out_ch.ready <= 1'b1;
        default: out_ch.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  int burst_left = 0;

  // Offer one transaction and hold it until it is taken. Between bursts,
  // sometimes drop valid for a random gap.
  task automatic send_item(input logic [7:0] data, input logic has, input logic close);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 1)) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    items_sent++;
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.has_byte <= has;
    in_ch.last_of_message <= close;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Send a whole message of the given length with random content; the
  // closing transaction carries the final byte or none.
  task automatic send_message(input int len, input bit close_with_byte);
    int body;
    body = (close_with_byte && len > 0) ? len - 1 : len;
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    if (close_with_byte && len > 0) send_item(8'($urandom), 1'b1, 1'b1);
    else send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, extreme bytes, ignored items.
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h3c, 1'b1, 1'b1);
    send_item(8'hc3, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // Padding boundaries: 55, 56, 63, 64 bytes.
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    send_message(63, 1'b1);
    send_message(64, 1'b0);

    // Long receiver hold-off while messages keep coming in.
    stall_hold <= 400;
    send_message(3, 1'b1);
    send_message(0, 1'b0);
    send_message(10, 1'b1);

    // Random messages, mostly short, a few past a block.
    while (items_sent < 460) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 140)
                                        : $urandom_range(0, 20);
      send_message(len, $urandom_range(0, 1));
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (fail_count == 0) begin
      $display("md5_message_digest_tb OK");
    end else begin
      $display("md5_message_digest_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("md5_message_digest_tb NOT OK");
    $finish;
  end

endmodule
